// ===== src/gedge_pkg.sv =====
// ----------------------------------------------------------------------------
// gedge_pkg
// Shared types, constants and helpers of the gradient edge threshold block.
// ----------------------------------------------------------------------------
package gedge_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int THR_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PROD_W = 2 * DIM_W;
    localparam int GRAD_W = PIX_W + 2;
    localparam int SUM_W  = GRAD_W + 1;
    localparam int ENTRY_W = 2 * PIX_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] MIN_DIM   = DIM_W'(3);

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MODE      = 2'd1,
        REG_WIDTH     = 2'd2,
        REG_HEIGHT    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_t;

    typedef enum logic {
        MODE_FWD_DIFF = 1'b0,
        MODE_SOBEL    = 1'b1
    } op_mode_t;

    typedef logic [PIX_W-1:0] pix_t;

    // [row][column], column 2 is the newest
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic emit;
        logic calc;
        logic last;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [COL_W-1:0] col;
        pix_t             px;
    } s1_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < MIN_DIM)
        begin
            r = MIN_DIM;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic logic [GRAD_W-1:0] absdiff(input logic [GRAD_W-1:0] a,
                                                  input logic [GRAD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== src/gradient_edge_threshold.sv =====
// ----------------------------------------------------------------------------
// gradient_edge_threshold
// Streaming 3x3 edge detector: row memory, window, gradient and threshold.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the row memory read, the window, the gradient
//   registers and the output queue; in stream terms result k follows item k+W+1.
// Throughput: one item per cycle while the output queue has room, set by the
//   single row memory that is read once at accept and written once in the next cycle.
// Reset: counters, window, pipeline and output queue clear; registers return
//   to threshold 0, mode 0, 1024 x 1024. The row memory is not cleared.
module gradient_edge_threshold
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] req_type
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tlast,   // frame_last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [gedge_pkg::THR_W-1:0] threshold_reg;
    gedge_pkg::op_mode_t         op_mode_reg;
    logic [gedge_pkg::DIM_W-1:0] frame_width_reg;
    logic [gedge_pkg::DIM_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            op_mode_reg      <= gedge_pkg::MODE_FWD_DIFF;
            frame_width_reg  <= gedge_pkg::DIM_W'(1024);
            frame_height_reg <= gedge_pkg::DIM_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gedge_pkg::cfg_reg_t'(cfg_index))
                gedge_pkg::REG_THRESHOLD: threshold_reg    <= cfg_data;
                gedge_pkg::REG_MODE:      op_mode_reg      <= gedge_pkg::op_mode_t'(cfg_data[0]);
                gedge_pkg::REG_WIDTH:     frame_width_reg  <= cfg_data;
                gedge_pkg::REG_HEIGHT:    frame_height_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: position counters, memory read issue
    // ------------------------------------------------------------------------
    logic [gedge_pkg::COL_W-1:0]  in_column_reg, in_column_next;
    logic [gedge_pkg::CNT_W-1:0]  in_row_reg,    in_row_next;
    logic [gedge_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    logic [gedge_pkg::DIM_W-1:0]  dim_w, dim_h;
    logic [gedge_pkg::PROD_W-1:0] frame_area;
    logic [gedge_pkg::DIM_W-1:0]  col_inc;
    logic [gedge_pkg::CNT_W-1:0]  cur_r;
    logic [gedge_pkg::DIM_W-1:0]  cur_c;
    logic                         row_in_frame, ignore_item, col_first;
    logic                         emit0, fd_ok, sob_ok, last0;
    gedge_pkg::pix_t              px0;
    logic                         s_accept, launch;

    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        dim_w        = gedge_pkg::clamp_dim(frame_width_reg,  gedge_pkg::MAX_W_DIM);
        dim_h        = gedge_pkg::clamp_dim(frame_height_reg, gedge_pkg::MAX_H_DIM);
        frame_area   = gedge_pkg::PROD_W'(dim_w) * gedge_pkg::PROD_W'(dim_h);
        row_in_frame = in_row_reg < gedge_pkg::CNT_W'(dim_h);
        ignore_item  = row_in_frame && (gedge_pkg::req_t'(s_tuser) == gedge_pkg::REQ_FLUSH);
        px0          = row_in_frame ? s_tdata : '0;
        col_first    = (in_column_reg == '0);
        emit0        = (in_row_reg >= gedge_pkg::CNT_W'(2))
                       || ((in_row_reg == gedge_pkg::CNT_W'(1)) && !col_first);
        cur_r        = col_first ? in_row_reg - gedge_pkg::CNT_W'(2)
                                 : in_row_reg - gedge_pkg::CNT_W'(1);
        cur_c        = col_first ? dim_w - gedge_pkg::DIM_W'(1)
                                 : gedge_pkg::DIM_W'(in_column_reg) - gedge_pkg::DIM_W'(1);
        fd_ok        = (cur_r <= gedge_pkg::CNT_W'(dim_h) - gedge_pkg::CNT_W'(2))
                       && (cur_c <= dim_w - gedge_pkg::DIM_W'(2));
        sob_ok       = fd_ok && (cur_r != '0) && (cur_c != '0);
        last0        = emit0 && ((gedge_pkg::PROD_W'(out_count_reg) + gedge_pkg::PROD_W'(1))
                                 >= frame_area);
        col_inc      = gedge_pkg::DIM_W'(in_column_reg) + gedge_pkg::DIM_W'(1);
        launch       = s_accept && !ignore_item;

        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        if (launch)
        begin
            if (col_inc >= dim_w)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + gedge_pkg::CNT_W'(1);
            end
            else
            begin
                in_column_next = col_inc[gedge_pkg::COL_W-1:0];
            end
            if (emit0)
            begin
                if (last0)
                begin
                    in_column_next = '0;
                    in_row_next    = '0;
                    out_count_next = '0;
                end
                else
                begin
                    out_count_next = out_count_reg + gedge_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
            out_count_reg <= out_count_next;
        end
    end

    // ------------------------------------------------------------------------
    // row memory: entry holds {older row, previous row} of one column
    // ------------------------------------------------------------------------
    logic [gedge_pkg::ENTRY_W-1:0] row_mem [gedge_pkg::MAX_WIDTH];
    logic [gedge_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [gedge_pkg::ENTRY_W-1:0] wr_data;
    logic [gedge_pkg::ENTRY_W-1:0] wr_data_reg;
    logic [gedge_pkg::COL_W-1:0]   wr_addr_reg;
    logic                          wr_valid_reg;

    gedge_pkg::s1_t s1_reg;
    logic           s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            rd_data_reg <= row_mem[in_column_reg];
        end
        if (s1_valid_reg)
        begin
            row_mem[s1_reg.col] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            s1_reg.tag.emit <= emit0;
            s1_reg.tag.calc <= (op_mode_reg == gedge_pkg::MODE_SOBEL) ? sob_ok : fd_ok;
            s1_reg.tag.last <= last0;
            s1_reg.col      <= in_column_reg;
            s1_reg.px       <= px0;
        end
        if (s1_valid_reg)
        begin
            wr_data_reg <= wr_data;
            wr_addr_reg <= s1_reg.col;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: forward the last write, shift the window, write back
    // ------------------------------------------------------------------------
    logic [gedge_pkg::ENTRY_W-1:0] entry;
    gedge_pkg::pix_t               top_px, mid_px;
    gedge_pkg::window_t            window_reg, window_next;

    always_comb
    begin
        // a read issued in the same cycle as a write to that column misses it
        entry  = (wr_valid_reg && (wr_addr_reg == s1_reg.col)) ? wr_data_reg : rd_data_reg;
        top_px = entry[gedge_pkg::ENTRY_W-1:gedge_pkg::PIX_W];
        mid_px = entry[gedge_pkg::PIX_W-1:0];
        wr_data = {mid_px, s1_reg.px};

        window_next = window_reg;
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = top_px;
        window_next[1][2] = mid_px;
        window_next[2][2] = s1_reg.px;
    end

    gedge_pkg::tag_t s2_reg;
    logic            s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            wr_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            window_reg   <= window_next;
            wr_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_reg <= s1_reg.tag;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: absolute differences of the window
    // ------------------------------------------------------------------------
    logic [gedge_pkg::GRAD_W-1:0] sum_bot, sum_top, sum_rgt, sum_lft;
    logic [gedge_pkg::GRAD_W-1:0] grad_a, grad_b;
    logic [gedge_pkg::GRAD_W-1:0] grad_a_reg, grad_b_reg;
    gedge_pkg::pix_t              center_reg;
    gedge_pkg::tag_t              s3_reg;
    logic                         s3_valid_reg;

    always_comb
    begin
        sum_bot = gedge_pkg::GRAD_W'(window_reg[2][0]) + {1'b0, window_reg[2][1], 1'b0}
                  + gedge_pkg::GRAD_W'(window_reg[2][2]);
        sum_top = gedge_pkg::GRAD_W'(window_reg[0][0]) + {1'b0, window_reg[0][1], 1'b0}
                  + gedge_pkg::GRAD_W'(window_reg[0][2]);
        sum_rgt = gedge_pkg::GRAD_W'(window_reg[0][2]) + {1'b0, window_reg[1][2], 1'b0}
                  + gedge_pkg::GRAD_W'(window_reg[2][2]);
        sum_lft = gedge_pkg::GRAD_W'(window_reg[0][0]) + {1'b0, window_reg[1][0], 1'b0}
                  + gedge_pkg::GRAD_W'(window_reg[2][0]);
        if (op_mode_reg == gedge_pkg::MODE_SOBEL)
        begin
            grad_a = gedge_pkg::absdiff(sum_bot, sum_top);
            grad_b = gedge_pkg::absdiff(sum_rgt, sum_lft);
        end
        else
        begin
            grad_a = gedge_pkg::absdiff(gedge_pkg::GRAD_W'(window_reg[1][1]),
                                        gedge_pkg::GRAD_W'(window_reg[1][2]));
            grad_b = gedge_pkg::absdiff(gedge_pkg::GRAD_W'(window_reg[1][1]),
                                        gedge_pkg::GRAD_W'(window_reg[2][1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            grad_a_reg <= grad_a;
            grad_b_reg <= grad_b;
            center_reg <= window_reg[1][1];
            s3_reg     <= s2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: threshold, push into the output queue
    // ------------------------------------------------------------------------
    logic [gedge_pkg::SUM_W-1:0] grad_sum;
    gedge_pkg::pix_t             result_px;
    logic                        fifo_push, fifo_pop;

    always_comb
    begin
        grad_sum  = gedge_pkg::SUM_W'(grad_a_reg) + gedge_pkg::SUM_W'(grad_b_reg);
        result_px = center_reg;
        if (s3_reg.calc)
        begin
            result_px = (grad_sum > threshold_reg) ? gedge_pkg::EDGE_ON : gedge_pkg::EDGE_OFF;
        end
        fifo_push = s3_valid_reg && s3_reg.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= launch;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // output queue; input is held back while queue plus pipeline could overflow
    // ------------------------------------------------------------------------
    logic [gedge_pkg::PIX_W:0]     fifo_data_reg [gedge_pkg::FIFO_DEPTH];
    logic [gedge_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [gedge_pkg::FIFO_AW:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [gedge_pkg::FIFO_AW:0]   occupancy;

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign fifo_pop = m_tvalid && m_tready;
    assign m_tdata  = fifo_data_reg[rd_ptr_reg][gedge_pkg::PIX_W-1:0];
    assign m_tlast  = fifo_data_reg[rd_ptr_reg][gedge_pkg::PIX_W];

    assign occupancy = fifo_cnt_reg + (gedge_pkg::FIFO_AW+1)'(s1_valid_reg)
                       + (gedge_pkg::FIFO_AW+1)'(s2_valid_reg)
                       + (gedge_pkg::FIFO_AW+1)'(s3_valid_reg);
    assign s_tready  = occupancy < (gedge_pkg::FIFO_AW+1)'(gedge_pkg::FIFO_DEPTH);

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push && !fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + (gedge_pkg::FIFO_AW+1)'(1);
        end
        else if (!fifo_push && fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - (gedge_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_data_reg[wr_ptr_reg] <= {s3_reg.last, result_px};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + gedge_pkg::FIFO_AW'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + gedge_pkg::FIFO_AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> ((fifo_cnt_reg < (gedge_pkg::FIFO_AW+1)'(gedge_pkg::FIFO_DEPTH))
                       || fifo_pop))
        else $error("output queue overflow");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (gedge_pkg::FIFO_AW+1)'(gedge_pkg::FIFO_DEPTH))
        else $error("queue plus pipeline exceeds queue depth");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (launch && last0) |=> ((in_column_reg == '0) && (in_row_reg == '0)
                               && (out_count_reg == '0)))
        else $error("frame end did not clear position");

    a_ignored_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && ignore_item) |=> ($stable(in_column_reg) && $stable(in_row_reg)
                                       && !s1_valid_reg))
        else $error("flush inside frame changed state");

endmodule

// ===== verif/gradient_edge_threshold_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_edge_threshold_test
// Self-checking bench for the streaming edge detector. A short table of
// 3x3 frames with known edge maps runs first. Random frames follow, in both
// operators and with clamped and extreme dimensions, with both stream sides
// stalling at random. Every output item is compared with its table value or a local predictor.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_test;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [10:0] THR_MAX        = 11'd2047;
    localparam logic [10:0] DIM_OVER       = 11'd2047;
    localparam logic [10:0] FWD_MAX_GRAD   = 11'd510;
    localparam logic [10:0] SOBEL_MAX_GRAD = 11'd2040;

    typedef struct packed {
        gedge_pkg::pix_t px;
        logic            last;
    } edge_res_t;

    typedef struct {
        bit                  is_cfg;
        gedge_pkg::cfg_reg_t idx;
        logic [10:0]         val;
        gedge_pkg::req_t     kind;
        gedge_pkg::pix_t     px;
        bit                  typed;
        edge_res_t           res;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tuser   = gedge_pkg::REQ_PIXEL;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = gedge_pkg::REG_THRESHOLD;
    logic [10:0] cfg_data  = 11'd0;

    // predictor copy of the registers and the pipeline state
    logic [10:0]         cfg_thr    = 11'd0;
    gedge_pkg::op_mode_t cfg_mode   = gedge_pkg::MODE_FWD_DIFF;
    logic [10:0]         cfg_width  = 11'd1024;
    logic [10:0]         cfg_height = 11'd1024;
    gedge_pkg::pix_t     line_prev  [gedge_pkg::MAX_WIDTH];
    gedge_pkg::pix_t     line_older [gedge_pkg::MAX_WIDTH];
    gedge_pkg::pix_t     win        [3][3];
    int                  pos_col    = 0;
    int                  pos_row    = 0;
    int                  out_seen   = 0;

    edge_res_t   edge_map_q [$];
    int          bad_count    = 0;
    int          random_count = 0;
    int unsigned cycle_count  = 0;
    bit          calm         = 1'b0;

    gradient_edge_threshold dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic void note_bad(input string msg);
        if (bad_count < REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        bad_count++;
    endfunction

    function automatic int span_limit(input logic [10:0] raw, input int top);
        int v;
        v = int'(raw);
        if (v < 3)
        begin
            return 3;
        end
        if (v > top)
        begin
            return top;
        end
        return v;
    endfunction

    function automatic int magnitude_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // one accepted item through the row memory and the window
    task automatic edge_predict(input gedge_pkg::req_t kind, input gedge_pkg::pix_t px_in,
                                output bit got, output edge_res_t res);
        int              w;
        int              h;
        int              cr;
        int              cc;
        int              g;
        int              bot;
        int              upr;
        int              rgt;
        int              lft;
        gedge_pkg::pix_t px;
        gedge_pkg::pix_t top;
        gedge_pkg::pix_t mid;
        gedge_pkg::pix_t ctr;
        bit              emit;
        w = span_limit(cfg_width, gedge_pkg::MAX_WIDTH);
        h = span_limit(cfg_height, gedge_pkg::MAX_HEIGHT);
        got = 1'b0;
        res = '0;
        px = px_in;
        if (pos_row < h)
        begin
            if (kind == gedge_pkg::REQ_FLUSH)
            begin
                return;
            end
        end
        else
        begin
            px = '0;
        end
        top = line_older[pos_col];
        mid = line_prev[pos_col];
        line_older[pos_col] = mid;
        line_prev[pos_col] = px;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        emit = (pos_row >= 2) || (pos_row == 1 && pos_col >= 1);
        if (pos_col == 0)
        begin
            cr = pos_row - 2;
            cc = w - 1;
        end
        else
        begin
            cr = pos_row - 1;
            cc = pos_col - 1;
        end
        pos_col++;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (!emit)
        begin
            return;
        end

        ctr = win[1][1];
        res.px = ctr;
        if (cfg_mode == gedge_pkg::MODE_FWD_DIFF)
        begin
            if (cr + 2 <= h && cc + 2 <= w)
            begin
                g = magnitude_gap(int'(ctr), int'(win[1][2]))
                    + magnitude_gap(int'(ctr), int'(win[2][1]));
                res.px = (g > int'(cfg_thr)) ? gedge_pkg::EDGE_ON : gedge_pkg::EDGE_OFF;
            end
        end
        else if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w)
        begin
            bot = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]);
            upr = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]);
            rgt = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]);
            lft = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]);
            g = magnitude_gap(bot, upr) + magnitude_gap(rgt, lft);
            res.px = (g > int'(cfg_thr)) ? gedge_pkg::EDGE_ON : gedge_pkg::EDGE_OFF;
        end
        got = 1'b1;
        if (out_seen + 1 >= w * h)
        begin
            res.last = 1'b1;
            pos_col = 0;
            pos_row = 0;
            out_seen = 0;
        end
        else
        begin
            out_seen++;
        end
    endtask

    task automatic push_item(input gedge_pkg::req_t kind, input gedge_pkg::pix_t px,
                             input bit typed, input edge_res_t known);
        bit        got;
        edge_res_t res;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        edge_predict(kind, px, got, res);
        if (got)
        begin
            edge_map_q.push_back(typed ? known : res);
        end
    endtask

    // hold the input until every expected item is out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (edge_map_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input gedge_pkg::cfg_reg_t idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            gedge_pkg::REG_THRESHOLD: cfg_thr    = val;
            gedge_pkg::REG_MODE:      cfg_mode   = gedge_pkg::op_mode_t'(val[0]);
            gedge_pkg::REG_WIDTH:     cfg_width  = val;
            gedge_pkg::REG_HEIGHT:    cfg_height = val;
        endcase
    endtask

    task automatic reconfigure(input logic [10:0] thr, input gedge_pkg::op_mode_t mode,
                               input logic [10:0] w, input logic [10:0] h);
        wait_drained();
        cfg_write(gedge_pkg::REG_THRESHOLD, thr);
        cfg_write(gedge_pkg::REG_MODE, 11'(mode));
        cfg_write(gedge_pkg::REG_WIDTH, w);
        cfg_write(gedge_pkg::REG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    function automatic gedge_pkg::pix_t pick_pixel();
        case ($urandom_range(0, 3))
            0:       return gedge_pkg::EDGE_OFF;
            1:       return gedge_pkg::EDGE_ON;
            default: return gedge_pkg::pix_t'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] pick_dim();
        if ($urandom_range(0, 7) == 0)
        begin
            return 11'($urandom_range(0, 2));
        end
        return 11'($urandom_range(3, 9));
    endfunction

    // one whole frame: pixels with stray flushes, then the drain items
    task automatic run_frame(input bit counted);
        int w;
        int h;
        w = span_limit(cfg_width, gedge_pkg::MAX_WIDTH);
        h = span_limit(cfg_height, gedge_pkg::MAX_HEIGHT);
        for (int n = 0; n < w * h + w + 1; n++)
        begin
            if (n < w * h)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    push_item(gedge_pkg::REQ_FLUSH, gedge_pkg::pix_t'($urandom), 1'b0, '0);
                end
                push_item(gedge_pkg::REQ_PIXEL, pick_pixel(), 1'b0, '0);
            end
            else
            begin
                push_item(($urandom_range(0, 4) == 0) ? gedge_pkg::REQ_PIXEL
                                                      : gedge_pkg::REQ_FLUSH,
                          gedge_pkg::pix_t'($urandom), 1'b0, '0);
            end
            if (counted)
            begin
                random_count++;
            end
            calm = counted && random_count >= 150 && random_count < 300;
            if ($urandom_range(0, 199) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    function automatic plan_row_t cfg_row(input gedge_pkg::cfg_reg_t idx,
                                          input logic [10:0] val);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.kind   = gedge_pkg::REQ_PIXEL;
        r.px     = '0;
        r.typed  = 1'b0;
        r.res    = '0;
        return r;
    endfunction

    function automatic plan_row_t item_row(input gedge_pkg::req_t kind,
                                           input gedge_pkg::pix_t px);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = gedge_pkg::REG_THRESHOLD;
        r.val    = '0;
        r.kind   = kind;
        r.px     = px;
        r.typed  = 1'b0;
        r.res    = '0;
        return r;
    endfunction

    function automatic plan_row_t known_row(input gedge_pkg::req_t kind,
                                            input gedge_pkg::pix_t px,
                                            input gedge_pkg::pix_t exp_px,
                                            input logic exp_last);
        plan_row_t r;
        r = item_row(kind, px);
        r.typed    = 1'b1;
        r.res.px   = exp_px;
        r.res.last = exp_last;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_output
        edge_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (edge_map_q.size() == 0)
            begin
                note_bad($sformatf("unexpected output item pixel=%0d last=%0b",
                                   m_tdata, m_tlast));
            end
            else
            begin
                want = edge_map_q.pop_front();
                if (m_tdata !== want.px || m_tlast !== want.last)
                begin
                    note_bad($sformatf("expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                                       want.px, want.last, m_tdata, m_tlast));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t           plan [$];
        bit                  cfg_open;
        logic [10:0]         thr;
        gedge_pkg::op_mode_t mode;
        cfg_open = 1'b0;
        foreach (line_prev[i])
        begin
            line_prev[i]  = '0;
            line_older[i] = '0;
        end
        foreach (win[r, c])
        begin
            win[r][c] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frames; outputs trail the inputs by four positions
        plan = '{
            cfg_row(gedge_pkg::REG_WIDTH, 11'd0),
            cfg_row(gedge_pkg::REG_HEIGHT, 11'd0),
            cfg_row(gedge_pkg::REG_MODE, 11'(gedge_pkg::MODE_FWD_DIFF)),
            cfg_row(gedge_pkg::REG_THRESHOLD, THR_MAX),
            item_row(gedge_pkg::REQ_PIXEL, 8'd0),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            item_row(gedge_pkg::REQ_FLUSH, 8'hA5),          // inside the frame: dropped
            item_row(gedge_pkg::REQ_PIXEL, 8'd0),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            known_row(gedge_pkg::REQ_PIXEL, 8'd0, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd0, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd128, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd77, 8'd0, 1'b0),  // past the frame: drains
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd128, 1'b1),
            cfg_row(gedge_pkg::REG_MODE, 11'(gedge_pkg::MODE_SOBEL)),
            cfg_row(gedge_pkg::REG_THRESHOLD, 11'd0),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            item_row(gedge_pkg::REQ_PIXEL, 8'd255),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_PIXEL, 8'd255, 8'd0, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b0),
            known_row(gedge_pkg::REQ_FLUSH, 8'd0, 8'd255, 1'b1)
        };
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (!cfg_open)
                begin
                    wait_drained();
                end
                cfg_write(plan[i].idx, plan[i].val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                push_item(plan[i].kind, plan[i].px, plan[i].typed, plan[i].res);
            end
        end

        // a height past the maximum clamps; run a few rows, then a small
        // frame size ends the frame on the next item
        reconfigure(11'($urandom_range(0, 1200)), gedge_pkg::MODE_SOBEL, 11'd3, DIM_OVER);
        for (int n = 0; n < 15; n++)
        begin
            push_item(gedge_pkg::REQ_PIXEL, pick_pixel(), 1'b0, '0);
        end
        reconfigure(11'($urandom_range(0, 300)), gedge_pkg::MODE_FWD_DIFF, 11'd0, 11'd0);
        push_item(gedge_pkg::REQ_FLUSH, 8'd0, 1'b0, '0);

        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0 || random_count == 0)
            begin
                mode = gedge_pkg::op_mode_t'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0:       thr = 11'd0;
                    1:       thr = THR_MAX;
                    2:       thr = (mode == gedge_pkg::MODE_SOBEL) ? SOBEL_MAX_GRAD
                                                                   : FWD_MAX_GRAD;
                    default: thr = 11'($urandom_range(0,
                                       (mode == gedge_pkg::MODE_SOBEL) ? 1200 : 300));
                endcase
                reconfigure(thr, mode, pick_dim(), pick_dim());
            end
            run_frame(1'b1);
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (edge_map_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (bad_count == 0 && edge_map_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gedge_pkg.sv
src/gradient_edge_threshold.sv
verif/gradient_edge_threshold_test.sv
